// ===== rtl/core/rog_pkg.sv =====
// Shared types and constants for the radius of gyration block.
// Holds field widths, configuration register codes and the sequencer state type.
// No dependencies.
`default_nettype none

package rog_pkg;

	localparam int COORD_W           = 20;
	localparam int FIRST_W           = 12;
	localparam int END_W             = 13;
	localparam int CFG_W             = 13;
	localparam int MAX_ATOMS_DEFAULT = 4096;
	localparam int S_TDATA_W         = 64;
	localparam int M_TDATA_W         = 24;

	localparam logic [FIRST_W-1:0] FIRST_RESET = 12'd0;
	localparam logic [END_W-1:0]   END_RESET   = 13'd4096;

	typedef enum logic {
		REG_FIRST_ATOM = 1'b0,
		REG_WINDOW_END = 1'b1
	} rog_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_DEN,
		ST_TOTAL,
		ST_CX,
		ST_CY,
		ST_CZ,
		ST_DIV,
		ST_ROOT,
		ST_DONE
	} rog_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/radius_of_gyration.sv =====
// Radius of gyration over a stream of atoms, with shift-add multiply,
// restoring divide and bit-pair square root on one sequencer.
// Depends on rog_pkg.
//
//   channel  dir  payload                                          handshake
//   s_*      in   tdata: coord_x, coord_y, coord_z; tuser: is_hydrogen;
//                 tlast: last_atom                                  tvalid/tready
//   m_*      out  tdata: gyration_radius; tuser: empty_set          tvalid/tready
//   cfg_*    in   index 0 first_atom, 1 window end                  write enable
//
// A skipped atom takes only its transfer; a counted atom takes its transfer plus four
// steps through the 20x20 squarer. The last atom adds the final sequence: n*n
// and n*Q by shift-add, then each |S|^2 term by shift-add, then the divide and the root.
// Reset clears sums, counters and the registers (window end to 4096).
// s_tready is high only while idle; a held result stalls only the hand-off of the next result.
`default_nettype none

module radius_of_gyration
	import rog_pkg::*;
#(
	parameter int MAX_ATOMS = MAX_ATOMS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // coord_x [19:0], coord_y [39:20], coord_z [59:40]
	input  logic                 s_tuser,   // is_hydrogen
	input  logic                 s_tlast,   // last_atom
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // gyration_radius [19:0]
	output logic                 m_tuser,   // empty_set
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int CNT_W  = $clog2(MAX_ATOMS + 1);
	localparam int LOG_N  = $clog2(MAX_ATOMS);
	localparam int SUM_W  = COORD_W + LOG_N;
	localparam int SQ_W   = 2 * COORD_W + LOG_N;
	localparam int ACC_W  = CNT_W + SQ_W + 1;
	localparam int DEN_W  = 2 * CNT_W;
	localparam int QW     = 2 * COORD_W;
	localparam int STEP_W = $clog2(ACC_W);
	localparam int CMP_W  = (CNT_W > END_W) ? CNT_W : END_W;

	localparam logic [1:0]       SQ_LAST   = 2'd3;
	localparam logic [QW-1:0]    ROOT_BIT0 = {2'b01, {(QW-2){1'b0}}};
	localparam logic [CNT_W-1:0] POS_MAX   = CNT_W'(MAX_ATOMS);

	rog_state_t state_q, state_d;
	logic       start_final;

	logic [FIRST_W-1:0]      first_q;
	logic [END_W-1:0]        end_q;
	logic [CNT_W-1:0]        pos_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic [SQ_W-1:0]         sumsq_q;
	logic [1:0]              sq_k_q;

	logic                    last_q;
	logic [COORD_W-1:0]      mag_x_q, mag_y_q, mag_z_q;
	logic [2*COORD_W-1:0]    prod_q;
	logic [ACC_W-1:0]        acc_q;
	logic [ACC_W-1:0]        mcand_q;
	logic [SUM_W-1:0]        mplier_q;
	logic [DEN_W-1:0]        den_q;
	logic [DEN_W-1:0]        rem_q;
	logic [STEP_W-1:0]       step_q;
	logic [QW-1:0]           root_q;
	logic [QW-1:0]           bit_q;

	logic                    m_tvalid_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;
	logic                    m_tuser_q;

	logic signed [COORD_W-1:0] coord_x, coord_y, coord_z;
	logic                      in_xfer;
	logic                      in_window;
	logic                      out_free;
	logic [COORD_W-1:0]        sq_sel;
	logic [2*COORD_W-1:0]      sq_prod;
	logic                      mul_done;
	logic [ACC_W-1:0]          mul_term;
	logic [SUM_W-1:0]          mag_sx, mag_sy, mag_sz;
	logic [DEN_W:0]            div_shift, div_diff;
	logic                      div_ge;
	logic [QW:0]               root_trial;
	logic                      root_ge;
	logic [COORD_W-1:0]        radius_sat;

	assign coord_x = s_tdata[COORD_W-1:0];
	assign coord_y = s_tdata[2*COORD_W-1:COORD_W];
	assign coord_z = s_tdata[3*COORD_W-1:2*COORD_W];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign in_window = !s_tuser
		&& (CMP_W'(pos_q) >= CMP_W'(first_q))
		&& (CMP_W'(pos_q) < CMP_W'(end_q))
		&& (pos_q < POS_MAX);

	always_comb begin
		unique case (sq_k_q)
			2'd0:    sq_sel = mag_x_q;
			2'd1:    sq_sel = mag_y_q;
			default: sq_sel = mag_z_q;
		endcase
	end
	assign sq_prod = sq_sel * sq_sel;

	// shared shift-add multiply step
	assign mul_done = (mplier_q == '0);
	assign mul_term = mplier_q[0] ? mcand_q : '0;

	assign mag_sx = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
	assign mag_sy = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
	assign mag_sz = sum_z_q[SUM_W-1] ? SUM_W'(-sum_z_q) : SUM_W'(sum_z_q);

	// restoring divide: numerator shifts out of acc, quotient bits shift in
	assign div_shift = {rem_q, acc_q[ACC_W-2]};
	assign div_diff  = div_shift - {1'b0, den_q};
	assign div_ge    = !div_diff[DEN_W];

	assign root_trial = {1'b0, root_q} + {1'b0, bit_q};
	assign root_ge    = ({1'b0, acc_q[QW-1:0]} >= root_trial);

	assign radius_sat = (|root_q[QW-1:COORD_W]) ? '1 : root_q[COORD_W-1:0];

	always_comb begin
		state_d     = state_q;
		start_final = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_window) begin
						state_d = ST_SQUARE;
					end else if (s_tlast) begin
						start_final = 1'b1;
					end
				end
			end
			ST_SQUARE: begin
				if (sq_k_q == SQ_LAST) begin
					if (last_q) begin
						start_final = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DEN: begin
				if (mul_done) state_d = ST_TOTAL;
			end
			ST_TOTAL: begin
				if (mul_done) state_d = ST_CX;
			end
			ST_CX: begin
				if (mul_done) state_d = ST_CY;
			end
			ST_CY: begin
				if (mul_done) state_d = ST_CZ;
			end
			ST_CZ: begin
				if (mul_done) state_d = acc_q[ACC_W-1] ? ST_ROOT : ST_DIV;
			end
			ST_DIV: begin
				if (step_q == STEP_W'(ACC_W - 2)) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (bit_q == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (start_final) begin
			state_d = (count_q == '0) ? ST_DONE : ST_DEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			first_q    <= FIRST_RESET;
			end_q      <= END_RESET;
			pos_q      <= '0;
			count_q    <= '0;
			sum_x_q    <= '0;
			sum_y_q    <= '0;
			sum_z_q    <= '0;
			sumsq_q    <= '0;
			sq_k_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_FIRST_ATOM: first_q <= cfg_wdata[FIRST_W-1:0];
					REG_WINDOW_END: end_q   <= cfg_wdata[END_W-1:0];
					default: ;
				endcase
			end

			if (in_xfer) begin
				sq_k_q <= '0;
				if (pos_q < POS_MAX) pos_q <= pos_q + 1'b1;
				if (in_window) begin
					sum_x_q <= sum_x_q + SUM_W'(coord_x);
					sum_y_q <= sum_y_q + SUM_W'(coord_y);
					sum_z_q <= sum_z_q + SUM_W'(coord_z);
					count_q <= count_q + 1'b1;
				end
			end

			if (state_q == ST_SQUARE) begin
				sq_k_q <= sq_k_q + 1'b1;
				if (sq_k_q != 2'd0) sumsq_q <= sumsq_q + SQ_W'(prod_q);
			end

			// hand off the result, then clear for the next system
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
				pos_q      <= '0;
				count_q    <= '0;
				sum_x_q    <= '0;
				sum_y_q    <= '0;
				sum_z_q    <= '0;
				sumsq_q    <= '0;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			last_q  <= s_tlast;
			mag_x_q <= coord_x[COORD_W-1] ? COORD_W'(-coord_x) : COORD_W'(coord_x);
			mag_y_q <= coord_y[COORD_W-1] ? COORD_W'(-coord_y) : COORD_W'(coord_y);
			mag_z_q <= coord_z[COORD_W-1] ? COORD_W'(-coord_z) : COORD_W'(coord_z);
		end

		if (state_q == ST_SQUARE && sq_k_q != SQ_LAST) prod_q <= sq_prod;

		if (start_final) begin
			acc_q    <= '0;
			mcand_q  <= ACC_W'(count_q);
			mplier_q <= SUM_W'(count_q);
			root_q   <= '0;
		end

		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= M_TDATA_W'(radius_sat);
			m_tuser_q <= (count_q == '0);
		end

		unique case (state_q)
			ST_DEN: begin
				if (!mul_done) begin
					acc_q    <= acc_q + mul_term;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end else begin
					den_q    <= acc_q[DEN_W-1:0];
					acc_q    <= '0;
					mcand_q  <= ACC_W'(sumsq_q);
					mplier_q <= SUM_W'(count_q);
				end
			end
			ST_TOTAL: begin
				if (!mul_done) begin
					acc_q    <= acc_q + mul_term;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end else begin
					mcand_q  <= ACC_W'(mag_sx);
					mplier_q <= mag_sx;
				end
			end
			ST_CX: begin
				if (!mul_done) begin
					acc_q    <= acc_q - mul_term;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end else begin
					mcand_q  <= ACC_W'(mag_sy);
					mplier_q <= mag_sy;
				end
			end
			ST_CY: begin
				if (!mul_done) begin
					acc_q    <= acc_q - mul_term;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end else begin
					mcand_q  <= ACC_W'(mag_sz);
					mplier_q <= mag_sz;
				end
			end
			ST_CZ: begin
				if (!mul_done) begin
					acc_q    <= acc_q - mul_term;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end else begin
					rem_q  <= '0;
					step_q <= '0;
					bit_q  <= ROOT_BIT0;
					// clamp a negative variance to zero
					if (acc_q[ACC_W-1]) acc_q <= '0;
				end
			end
			ST_DIV: begin
				acc_q  <= {acc_q[ACC_W-2:0], div_ge};
				rem_q  <= div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
				step_q <= step_q + 1'b1;
			end
			ST_ROOT: begin
				if (bit_q != '0) begin
					if (root_ge) begin
						acc_q[QW-1:0] <= acc_q[QW-1:0] - root_trial[QW-1:0];
						root_q        <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for radius_of_gyration: streams atom systems through the
// block and compares each radius result with an in-bench prediction.
// Depends on rog_pkg and radius_of_gyration.
`default_nettype none

module tb;
	import rog_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE      = 400;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		bit                        hydrogen;
		bit                        last;
	} atom_t;

	typedef struct {
		logic [COORD_W-1:0] radius;
		bit                 empty;
	} gyration_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;   // coord_x [19:0], coord_y [39:20], coord_z [59:40]
	logic                 s_tuser   = 1'b0; // is_hydrogen
	logic                 s_tlast   = 1'b0; // last_atom
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;          // gyration_radius [19:0]
	logic                 m_tuser;          // empty_set
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = REG_FIRST_ATOM;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	radius_of_gyration dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	atom_t     atom_queue[$];
	gyration_t radius_queue[$];
	atom_t     held_atom;
	gyration_t got;
	gyration_t want;

	int  atoms_queued  = 0;
	int  atoms_taken   = 0;
	int  errors        = 0;
	int  cycles        = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;

	// window copy and running sums of the current system
	logic [FIRST_W-1:0] win_first = FIRST_RESET;
	logic [END_W-1:0]   win_end   = END_RESET;
	int                 position  = 0;
	longint             sum_x     = 0;
	longint             sum_y     = 0;
	longint             sum_z     = 0;
	longint unsigned    sum_sq    = 0;
	longint unsigned    counted   = 0;

	// per-phase windows; -1 picks a random small bound
	int phase_first[12] = '{2, 0, 0, 9, 1, 0, 4095, -1, -1, 0, 3, -1};
	int phase_end[12]   = '{20, 4096, 0, 4, 2, 8, 4096, -1, -1, 4096, 30, -1};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void accumulate_atom(atom_t a);
		longint unsigned mx, my, mz, n;
		logic [127:0]    total, centre, rg2, cand;
		logic [63:0]     rg;
		if (!a.hydrogen && position >= win_first && position < win_end &&
				position < MAX_ATOMS_DEFAULT) begin
			mx = (a.x < 0) ? -longint'(a.x) : longint'(a.x);
			my = (a.y < 0) ? -longint'(a.y) : longint'(a.y);
			mz = (a.z < 0) ? -longint'(a.z) : longint'(a.z);
			sum_x += a.x;
			sum_y += a.y;
			sum_z += a.z;
			sum_sq += mx * mx + my * my + mz * mz;
			counted++;
		end
		if (position < MAX_ATOMS_DEFAULT)
			position++;
		if (!a.last)
			return;
		if (counted == 0) begin
			radius_queue.push_back('{radius: '0, empty: 1'b1});
		end else begin
			n = counted;
			mx = (sum_x < 0) ? -sum_x : sum_x;
			my = (sum_y < 0) ? -sum_y : sum_y;
			mz = (sum_z < 0) ? -sum_z : sum_z;
			total = 128'(n) * 128'(sum_sq);
			centre = 128'(mx) * 128'(mx) + 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
			rg2 = (total < centre) ? 128'd0 : 128'(64'((total - centre) / 128'(n * n)));
			rg = '0;
			// build the truncated root one bit at a time
			for (int b = 31; b >= 0; b--) begin
				cand = 128'(rg | (64'd1 << b));
				if (cand * cand <= rg2)
					rg = 64'(cand);
			end
			if (rg > 64'hFFFFF)
				rg = 64'hFFFFF;
			radius_queue.push_back('{radius: rg[COORD_W-1:0], empty: 1'b0});
		end
		position = 0;
		sum_x = 0;
		sum_y = 0;
		sum_z = 0;
		sum_sq = 0;
		counted = 0;
	endfunction

	// source side: hold the atom until its transfer, then load the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				accumulate_atom(held_atom);
				atoms_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (atom_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					held_atom = atom_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, held_atom.z, held_atom.y, held_atom.x};
					s_tuser  <= held_atom.hydrogen;
					s_tlast  <= held_atom.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side: random backpressure, check every result transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.radius = m_tdata[COORD_W-1:0];
				got.empty  = m_tuser;
				if (radius_queue.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: radius %0d empty %0d",
						$time, got.radius, got.empty);
				end else begin
					want = radius_queue.pop_front();
					if (got.radius !== want.radius) begin
						errors++;
						if (errors < 100)
							$display("%0t: gyration_radius expected %0d actual %0d",
								$time, want.radius, got.radius);
					end
					if (got.empty !== want.empty) begin
						errors++;
						if (errors < 100)
							$display("%0t: empty_set expected %0d actual %0d",
								$time, want.empty, got.empty);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_atom(int x, int y, int z, bit hydrogen, bit last);
		atom_queue.push_back('{x: COORD_W'(x), y: COORD_W'(y), z: COORD_W'(z),
			hydrogen: hydrogen, last: last});
		atoms_queued++;
	endtask

	function automatic int pick_coord(bit wide, int centre, int spread);
		if (wide)
			return int'($urandom);
		return centre + int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	// one system of len atoms, last flag on the final one
	task automatic push_system(int len, int hyd_pct);
		bit wide;
		int cx, cy, cz, spread;
		wide = ($urandom_range(99) < 30);
		cx = int'($urandom_range(0, 524288)) - 262144;
		cy = int'($urandom_range(0, 524288)) - 262144;
		cz = int'($urandom_range(0, 524288)) - 262144;
		spread = 1 << $urandom_range(0, 16);
		for (int i = 0; i < len; i++)
			push_atom(pick_coord(wide, cx, spread), pick_coord(wide, cy, spread),
				pick_coord(wide, cz, spread), $urandom_range(99) < hyd_pct, i == len - 1);
	endtask

	task automatic set_window(int first, int end_excl);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FIRST_ATOM;
		cfg_wdata <= CFG_W'(first);
		@(posedge clk);
		cfg_index <= REG_WINDOW_END;
		cfg_wdata <= CFG_W'(end_excl);
		@(posedge clk);
		cfg_we    <= 1'b0;
		win_first = FIRST_W'(first);
		win_end   = END_W'(end_excl);
	endtask

	// wait until every atom is taken and every radius checked, then let the
	// sequencer settle before touching the window
	task automatic drain();
		while (atoms_taken != atoms_queued || radius_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int first, end_excl, added, len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 34;
		recv_idle_pct = 87;
		set_window(0, 4096);

		// lone atom at the top corner: zero spread
		push_atom(524287, 524287, 524287, 0, 1);
		// opposite corners: widest spread
		push_atom(-524288, -524288, -524288, 0, 0);
		push_atom(524287, 524287, 524287, 0, 1);
		// hydrogens only: empty
		push_atom(1000, -2000, 3000, 1, 0);
		push_atom(-1, -1, -1, 1, 1);
		// hydrogen on the closing atom is still skipped
		push_atom(100, 0, 0, 0, 0);
		push_atom(-100, 0, 0, 0, 0);
		push_atom(524287, -524288, 7, 1, 1);
		// all at the origin
		push_atom(0, 0, 0, 0, 0);
		push_atom(0, 0, 0, 0, 0);
		push_atom(0, 0, 0, 0, 1);
		// tiny offsets truncate
		push_atom(1, 1, 1, 0, 0);
		push_atom(0, 0, 0, 0, 1);
		// mixed extremes per axis
		push_atom(-524288, 524287, 0, 0, 0);
		push_atom(524287, -524288, -1, 0, 1);
		drain();

		// empty window
		set_window(0, 0);
		push_atom(5, 6, 7, 0, 0);
		push_atom(-5, -6, -7, 0, 1);
		drain();
		// inverted window
		set_window(6, 2);
		for (int i = 0; i < 8; i++)
			push_atom(i * 300, -i * 70, i, 0, i == 7);
		drain();
		// single-position window
		set_window(1, 2);
		push_atom(10, 10, 10, 0, 0);
		push_atom(-4000, 2500, 99, 0, 0);
		push_atom(77, 77, 77, 0, 1);
		drain();

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 87 : 0;
			recv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 34 : 0;
			for (int slot = 0; slot < 4; slot++) begin
				first    = phase_first[mode * 4 + slot];
				end_excl = phase_end[mode * 4 + slot];
				if (first < 0)
					first = $urandom_range(0, 15);
				if (end_excl < 0)
					end_excl = $urandom_range(0, 50);
				set_window(first, end_excl);
				added = 0;
				while (added < 130) begin
					len = ($urandom_range(19) == 0) ? $urandom_range(41, 120)
						: $urandom_range(1, 30);
					// a few systems of hydrogens only, the rest mostly heavy atoms
					push_system(len, ($urandom_range(9) == 0) ? 100 : 20);
					added += len;
				end
				drain();
			end
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

// ===== radius_of_gyration.f =====
rtl/core/rog_pkg.sv
rtl/core/radius_of_gyration.sv
sim/tb.sv
